### hdl/acia_pkg.sv
// ----------------------------------------------------------------------------
// ACIA emulator package
// Shared types, codes and constants for the 6850-style serial chip emulator.
// ----------------------------------------------------------------------------
`default_nettype none

package acia_pkg;

  // Receive queue geometry
  localparam int QueueDepth = 256;
  localparam int IdxW       = $clog2(QueueDepth);
  localparam int CntW       = $clog2(QueueDepth + 1);

  // Event codes carried on the op field
  typedef enum logic [1:0] {
    OpKey      = 2'd0,
    OpBus      = 2'd1,
    OpBusReset = 2'd2
  } op_e;

  // Address decode and register values
  localparam logic [7:0] DecodeMask  = 8'hC0;
  localparam logic [7:0] DecodeMatch = 8'h80;
  localparam logic [7:0] StatusBase  = 8'h02;
  localparam logic [7:0] StatusRxFul = 8'h01;
  localparam logic [7:0] StatusReset = 8'h30;
  localparam logic [1:0] CtrlMaster  = 2'b11;

  // Queue commands from the register logic
  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] wdata;
  } rxq_ctrl_t;

  // Queue status towards the register logic
  typedef struct packed {
    logic       empty;
    logic       full;
    logic       several;
    logic [7:0] head;
  } rxq_stat_t;

  // Circular index advance with wrap at the queue depth
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    return (idx == IdxW'(QueueDepth - 1)) ? '0 : idx + 1'b1;
  endfunction

endpackage

`default_nettype wire

### hdl/acia_uart_register_emulator.sv
// ----------------------------------------------------------------------------
// ACIA UART register emulator
// Decodes processor I/O accesses to a 6850-style serial chip and serves its
// status, control and data registers from a receive queue of key bytes.
// ----------------------------------------------------------------------------
// An event is taken whenever start is high; busy is always low, so one
// event can be issued in every clock cycle. Each event gives exactly one
// result: the event is registered, decoded against the queue and flag
// state in the following cycle, and the result is then registered and
// appears for one cycle with done_o high. The receiver cannot stall, so a
// result must be captured in the cycle it is shown. The head of the receive
// queue is read from its memory at the same edge that registers the event,
// so it is ready for the decode; the result passes the input register and
// then the result register. The queue needs no clearing after reset.
`default_nettype none

module acia_uart_register_emulator (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_we_i,
  input  wire         cfg_wdata_i,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  op_i,
  input  wire  [7:0]  key_char_i,
  input  wire  [15:0] bus_addr_i,
  input  wire  [7:0]  bus_data_i,
  input  wire         io_request_i,
  input  wire         m1_cycle_i,
  input  wire         read_strobe_i,
  input  wire         write_strobe_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        read_valid_o,
  output logic        irq_pulse_o,
  output logic [7:0]  term_char_o,
  output logic        term_char_valid_o,
  output logic        key_passthrough_o
);
  import acia_pkg::*;

  // Configuration and chip flags
  logic emul_en_q;
  logic needs_reset_q, needs_reset_d;
  logic not_setup_q, not_setup_d;
  logic irq_en_q, irq_en_d;

  // Registered event
  logic        ev_vld_q;
  logic [1:0]  ev_op_q;
  logic [7:0]  ev_key_q;
  logic [15:0] ev_addr_q;
  logic [7:0]  ev_data_q;
  logic        ev_ioreq_q;
  logic        ev_m1_q;
  logic        ev_rd_q;
  logic        ev_wr_q;

  // Result register
  logic       done_q;
  logic [7:0] rdata_q, rdata_d;
  logic       rvalid_q, rvalid_d;
  logic       irq_q, irq_d;
  logic [7:0] tchar_q, tchar_d;
  logic       tvalid_q, tvalid_d;
  logic       pass_q, pass_d;

  rxq_ctrl_t q_ctrl;
  rxq_stat_t q_stat;

  logic       hit;
  logic       data_reg;
  logic [7:0] status;

  assign busy = 1'b0;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emul_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      emul_en_q <= cfg_wdata_i;
    end
  end

  // Event capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_vld_q <= 1'b0;
    end else begin
      ev_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      ev_op_q    <= op_i;
      ev_key_q   <= key_char_i;
      ev_addr_q  <= bus_addr_i;
      ev_data_q  <= bus_data_i;
      ev_ioreq_q <= io_request_i;
      ev_m1_q    <= m1_cycle_i;
      ev_rd_q    <= read_strobe_i;
      ev_wr_q    <= write_strobe_i;
    end
  end

  // Address decode and status byte
  assign hit = emul_en_q && ev_ioreq_q && !ev_m1_q &&
               ((ev_addr_q[7:0] & DecodeMask) == DecodeMatch);
  assign data_reg = ev_addr_q[0];

  always_comb begin
    status = StatusBase | (q_stat.empty ? 8'h00 : StatusRxFul);
    if (needs_reset_q) begin
      status = status | StatusReset;
    end else if (not_setup_q) begin
      status = '0;
    end
  end

  // Event decode: queue commands, flag updates and the result
  always_comb begin
    q_ctrl        = '0;
    q_ctrl.wdata  = ev_key_q;
    needs_reset_d = needs_reset_q;
    not_setup_d   = not_setup_q;
    irq_en_d      = irq_en_q;
    rdata_d       = '0;
    rvalid_d      = 1'b0;
    irq_d         = 1'b0;
    tchar_d       = '0;
    tvalid_d      = 1'b0;
    pass_d        = 1'b0;
    if (ev_vld_q) begin
      case (op_e'(ev_op_q))
        OpKey: begin
          if (!emul_en_q) begin
            pass_d = 1'b1;
          end else if (!q_stat.full) begin
            q_ctrl.push = 1'b1;
            irq_d       = irq_en_q;
          end
        end
        OpBus: begin
          if (hit && ev_rd_q) begin
            rvalid_d = 1'b1;
            if (!data_reg) begin
              rdata_d = status;
            end else begin
              if (!q_stat.empty) begin
                q_ctrl.pop = 1'b1;
                rdata_d    = q_stat.head;
                irq_d      = irq_en_q && q_stat.several;
              end
              needs_reset_d = 1'b0;
            end
          end else if (hit && ev_wr_q) begin
            if (!data_reg) begin
              irq_en_d = ev_data_q[7];
              if (ev_data_q[1:0] == CtrlMaster) begin
                needs_reset_d = 1'b0;
                not_setup_d   = 1'b1;
              end else begin
                not_setup_d = 1'b0;
              end
            end else begin
              tchar_d  = ev_data_q;
              tvalid_d = 1'b1;
            end
          end
        end
        OpBusReset: begin
          needs_reset_d = 1'b1;
          not_setup_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Flag and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needs_reset_q <= 1'b1;
      not_setup_q   <= 1'b0;
      irq_en_q      <= 1'b0;
      done_q        <= 1'b0;
      rdata_q       <= '0;
      rvalid_q      <= 1'b0;
      irq_q         <= 1'b0;
      tchar_q       <= '0;
      tvalid_q      <= 1'b0;
      pass_q        <= 1'b0;
    end else begin
      needs_reset_q <= needs_reset_d;
      not_setup_q   <= not_setup_d;
      irq_en_q      <= irq_en_d;
      done_q        <= ev_vld_q;
      rdata_q       <= rdata_d;
      rvalid_q      <= rvalid_d;
      irq_q         <= irq_d;
      tchar_q       <= tchar_d;
      tvalid_q      <= tvalid_d;
      pass_q        <= pass_d;
    end
  end

  acia_rxq u_rxq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (q_ctrl),
    .stat_o (q_stat)
  );

  assign done_o            = done_q;
  assign read_data_o       = rdata_q;
  assign read_valid_o      = rvalid_q;
  assign irq_pulse_o       = irq_q;
  assign term_char_o       = tchar_q;
  assign term_char_valid_o = tvalid_q;
  assign key_passthrough_o = pass_q;

  // Every transfer in gives a result after the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("result missing two cycles after an event");

  // Result flags only appear alongside the strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (read_valid_o || term_char_valid_o || irq_pulse_o || key_passthrough_o)
    |-> done_o)
    else $error("result flag without strobe");

  // One event never both reads and writes the chip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(read_valid_o && term_char_valid_o))
    else $error("read and terminal write in one result");

  // A passed-through key never touches the queue or raises an interrupt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_passthrough_o |-> !irq_pulse_o && !read_valid_o)
    else $error("passthrough key with queue side effects");

endmodule

`default_nettype wire

### hdl/acia_rxq.sv
// ----------------------------------------------------------------------------
// ACIA receive queue
// Circular byte queue with a registered read of the head entry and a bypass
// for a byte written to the slot that is about to become the head.
// ----------------------------------------------------------------------------
`default_nettype none

module acia_rxq (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire acia_pkg::rxq_ctrl_t ctrl_i,
  output acia_pkg::rxq_stat_t   stat_o
);
  import acia_pkg::*;

  logic [7:0]      mem [QueueDepth];
  logic [IdxW-1:0] put_q, put_d;
  logic [IdxW-1:0] get_q, get_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      head_q;
  logic            byp_q, byp_d;
  logic [7:0]      byp_data_q;

  // Pointer and fill count updates
  always_comb begin
    put_d = ctrl_i.push ? next_idx(put_q) : put_q;
    get_d = ctrl_i.pop ? next_idx(get_q) : get_q;
    cnt_d = cnt_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      cnt_d = cnt_q - 1'b1;
    end
    byp_d = ctrl_i.push && (put_q == get_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      put_q <= '0;
      get_q <= '0;
      cnt_q <= '0;
      byp_q <= 1'b0;
    end else begin
      put_q <= put_d;
      get_q <= get_d;
      cnt_q <= cnt_d;
      byp_q <= byp_d;
    end
  end

  // Storage: one write port, head read registered at the next get pointer
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[put_q] <= ctrl_i.wdata;
    end
    head_q     <= mem[get_d];
    byp_data_q <= ctrl_i.wdata;
  end

  assign stat_o.empty   = (cnt_q == '0);
  assign stat_o.full    = (cnt_q == CntW'(QueueDepth));
  assign stat_o.several = (cnt_q > CntW'(1));
  assign stat_o.head    = byp_q ? byp_data_q : head_q;

  // Fill count stays within the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("receive queue count beyond depth");

  // No push into a full queue unless a byte leaves in the same transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.push && stat_o.full) |-> ctrl_i.pop)
    else $error("push into full receive queue");

  // No pop from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop |-> !stat_o.empty)
    else $error("pop from empty receive queue");

endmodule

`default_nettype wire

### dv/acia_uart_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACIA emulator checker
// Watches event transfers and result strobes of the serial chip emulator,
// keeps its own copy of the receive queue and flags, and compares every
// result with the reply that it worked out when the event was taken.
// ----------------------------------------------------------------------------

module acia_uart_checker
  import acia_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  op_i,
  input  logic [7:0]  key_char_i,
  input  logic [15:0] bus_addr_i,
  input  logic [7:0]  bus_data_i,
  input  logic        io_request_i,
  input  logic        m1_cycle_i,
  input  logic        read_strobe_i,
  input  logic        write_strobe_i,
  input  logic        done_i,
  input  logic [7:0]  read_data_i,
  input  logic        read_valid_i,
  input  logic        irq_pulse_i,
  input  logic [7:0]  term_char_i,
  input  logic        term_char_valid_i,
  input  logic        key_passthrough_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  // One reply of the chip to one event
  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       irq;
    logic [7:0] term_char;
    logic       term_valid;
    logic       passthrough;
  } acia_reply_t;

  // Mirror of the chip state
  logic [7:0]      rx_bytes [QueueDepth];
  logic [IdxW-1:0] wr_ptr;
  logic [IdxW-1:0] rd_ptr;
  logic [CntW-1:0] rx_level;
  logic            needs_reset;
  logic            not_setup;
  logic            irq_enable;
  logic            emulating;

  acia_reply_t     awaited_replies [$];
  acia_reply_t     seen;
  acia_reply_t     want;
  int unsigned     mismatches;

  assign errors_o = mismatches;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned exp_val);
    if (got != exp_val)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, exp_val));
  endtask

  function automatic logic [IdxW-1:0] step_index(input logic [IdxW-1:0] idx);
    return (int'(idx) == QueueDepth - 1) ? '0 : idx + 1'b1;
  endfunction

  // Applies the event on the input ports to the mirror and returns its reply.
  function automatic acia_reply_t serve_event();
    acia_reply_t r;
    logic        hit;
    r = '0;
    case (op_i)
      OpKey: begin
        if (!emulating) begin
          r.passthrough = 1'b1;
        end else if (rx_level < CntW'(QueueDepth)) begin
          rx_bytes[wr_ptr] = key_char_i;
          wr_ptr = step_index(wr_ptr);
          rx_level = rx_level + 1'b1;
          r.irq = irq_enable;
        end
      end
      OpBus: begin
        hit = emulating && io_request_i && !m1_cycle_i &&
              ((bus_addr_i[7:0] & DecodeMask) == DecodeMatch);
        if (hit && read_strobe_i) begin
          r.read_valid = 1'b1;
          if (!bus_addr_i[0]) begin
            // Status register
            r.read_data = StatusBase | ((rx_level != 0) ? StatusRxFul : 8'h00);
            if (needs_reset) r.read_data = r.read_data | StatusReset;
            else if (not_setup) r.read_data = 8'h00;
          end else begin
            // Receive data register; an empty queue reads as zero
            if (rx_level != 0) begin
              r.read_data = rx_bytes[rd_ptr];
              rd_ptr = step_index(rd_ptr);
              rx_level = rx_level - 1'b1;
              r.irq = irq_enable && (rx_level != 0);
            end
            needs_reset = 1'b0;
          end
        end else if (hit && write_strobe_i) begin
          if (!bus_addr_i[0]) begin
            // Control register: a master reset code leaves the chip not set up
            irq_enable = bus_data_i[7];
            if (bus_data_i[1:0] == CtrlMaster) begin
              needs_reset = 1'b0;
              not_setup = 1'b1;
            end else begin
              not_setup = 1'b0;
            end
          end else begin
            r.term_char = bus_data_i;
            r.term_valid = 1'b1;
          end
        end
      end
      OpBusReset: begin
        needs_reset = 1'b1;
        not_setup = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Results are compared before the event of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr = '0;
      rd_ptr = '0;
      rx_level = '0;
      needs_reset = 1'b1;
      not_setup = 1'b0;
      irq_enable = 1'b0;
      emulating = 1'b1;
      awaited_replies.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        seen = '{read_data: read_data_i, read_valid: read_valid_i, irq: irq_pulse_i,
                 term_char: term_char_i, term_valid: term_char_valid_i,
                 passthrough: key_passthrough_i};
        if (awaited_replies.size() == 0) begin
          report_mismatch("result transfer with no event outstanding");
        end else begin
          want = awaited_replies.pop_front();
          check_field("read_data", seen.read_data, want.read_data);
          check_field("read_valid", seen.read_valid, want.read_valid);
          check_field("irq_pulse", seen.irq, want.irq);
          check_field("term_char", seen.term_char, want.term_char);
          check_field("term_char_valid", seen.term_valid, want.term_valid);
          check_field("key_passthrough", seen.passthrough, want.passthrough);
        end
      end
      if (start_i && !busy_i) awaited_replies.push_back(serve_event());
      if (cfg_we_i) emulating = cfg_wdata_i;
      pending_o <= awaited_replies.size();
    end
  end

endmodule

### dv/tb_acia_uart_register_emulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ACIA emulator testbench
// Drives key, bus access, bus reset and ignored-code events into the serial
// chip emulator with random gaps, fills and drains the receive queue, toggles
// emulation between phases and leaves the checking to the checker beside it.
// ----------------------------------------------------------------------------

module tb_acia_uart_register_emulator;
  import acia_pkg::*;

  // The op field can carry a fourth code that the block must ignore
  localparam logic [1:0] OpIgnored  = 2'd3;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  key;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        io;
    logic        m1;
    logic        rd;
    logic        wr;
  } chip_event_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic [7:0]  key_char;
  logic [15:0] bus_addr;
  logic [7:0]  bus_data;
  logic        io_request;
  logic        m1_cycle;
  logic        read_strobe;
  logic        write_strobe;
  logic        done;
  logic [7:0]  read_data;
  logic        read_valid;
  logic        irq_pulse;
  logic [7:0]  term_char;
  logic        term_char_valid;
  logic        key_passthrough;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycles;
  logic        idling;

  acia_uart_register_emulator DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .op_i              (op),
    .key_char_i        (key_char),
    .bus_addr_i        (bus_addr),
    .bus_data_i        (bus_data),
    .io_request_i      (io_request),
    .m1_cycle_i        (m1_cycle),
    .read_strobe_i     (read_strobe),
    .write_strobe_i    (write_strobe),
    .done_o            (done),
    .read_data_o       (read_data),
    .read_valid_o      (read_valid),
    .irq_pulse_o       (irq_pulse),
    .term_char_o       (term_char),
    .term_char_valid_o (term_char_valid),
    .key_passthrough_o (key_passthrough)
  );

  acia_uart_checker acia_check (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .start_i           (start),
    .busy_i            (busy),
    .op_i              (op),
    .key_char_i        (key_char),
    .bus_addr_i        (bus_addr),
    .bus_data_i        (bus_data),
    .io_request_i      (io_request),
    .m1_cycle_i        (m1_cycle),
    .read_strobe_i     (read_strobe),
    .write_strobe_i    (write_strobe),
    .done_i            (done),
    .read_data_i       (read_data),
    .read_valid_i      (read_valid),
    .irq_pulse_i       (irq_pulse),
    .term_char_i       (term_char),
    .term_char_valid_i (term_char_valid),
    .key_passthrough_i (key_passthrough),
    .errors_o          (errors),
    .pending_o         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Address that decodes to the chip, with random upper and middle bits
  function automatic logic [15:0] chip_addr(input logic data_reg);
    return {8'($urandom_range(255)), 2'b10, 5'($urandom_range(31)), data_reg};
  endfunction

  function automatic chip_event_t bus_event(input logic [15:0] addr, input logic [7:0] data,
                                            input logic io, input logic m1,
                                            input logic rd, input logic wr);
    chip_event_t ev;
    ev = '{op: OpBus, key: 8'($urandom_range(255)), addr: addr, data: data,
           io: io, m1: m1, rd: rd, wr: wr};
    return ev;
  endfunction

  function automatic chip_event_t other_event(input logic [1:0] code, input logic [7:0] key);
    chip_event_t ev;
    ev = bus_event(16'($urandom_range(65535)), 8'($urandom_range(255)),
                   1'($urandom_range(1)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'($urandom_range(1)));
    ev.op = code;
    ev.key = key;
    return ev;
  endfunction

  // Mostly well-formed register traffic, with some noise cycles mixed in
  function automatic chip_event_t random_event();
    chip_event_t ev;
    int unsigned pick;
    logic [7:0]  ctrl;
    pick = $urandom_range(99);
    ctrl = 8'($urandom_range(255));
    if ($urandom_range(2) == 0) ctrl[1:0] = CtrlMaster;
    if (pick < 30)
      ev = other_event(OpKey, 8'($urandom_range(255)));
    else if (pick < 42)
      ev = bus_event(chip_addr(1'b0), ctrl, 1'b1, 1'b0, 1'b1, 1'($urandom_range(1)));
    else if (pick < 62)
      ev = bus_event(chip_addr(1'b1), ctrl, 1'b1, 1'b0, 1'b1, 1'($urandom_range(1)));
    else if (pick < 70)
      ev = bus_event(chip_addr(1'b0), ctrl, 1'b1, 1'b0, 1'b0, 1'b1);
    else if (pick < 78)
      ev = bus_event(chip_addr(1'b1), ctrl, 1'b1, 1'b0, 1'b0, 1'b1);
    else if (pick < 90) begin
      ev = other_event(OpBus, 8'($urandom_range(255)));
      if ($urandom_range(1) == 1) ev.addr = chip_addr(1'($urandom_range(1)));
    end else if (pick < 95)
      ev = other_event(OpBusReset, 8'($urandom_range(255)));
    else
      ev = other_event(OpIgnored, 8'($urandom_range(255)));
    return ev;
  endfunction

  // One event transfer, preceded by random idle cycles when idling is on
  task automatic issue(input chip_event_t ev);
    while (idling && $urandom_range(99) < 34) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    op           <= ev.op;
    key_char     <= ev.key;
    bus_addr     <= ev.addr;
    bus_data     <= ev.data;
    io_request   <= ev.io;
    m1_cycle     <= ev.m1;
    read_strobe  <= ev.rd;
    write_strobe <= ev.wr;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // The enable register is only written once every result has come back
  task automatic write_emulation(input logic enable);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= enable;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic random_events(input int unsigned count);
    repeat (count) issue(random_event());
  endtask

  initial begin
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= 1'b0;
    start        <= 1'b0;
    op           <= OpKey;
    key_char     <= '0;
    bus_addr     <= '0;
    bus_data     <= '0;
    io_request   <= 1'b0;
    m1_cycle     <= 1'b0;
    read_strobe  <= 1'b0;
    write_strobe <= 1'b0;
    idling       = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_emulation(1'b1);

    // Directed: status after reset, empty data read, master reset, irq
    // enable, key extremes, read priority, decode misses and odd codes
    issue(bus_event(16'h0080, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    issue(bus_event(16'h0081, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    issue(bus_event(16'h0080, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    issue(bus_event(16'h0080, 8'h03, 1'b1, 1'b0, 1'b0, 1'b1));
    issue(bus_event(16'h0080, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    issue(bus_event(16'hFFBE, 8'h80, 1'b1, 1'b0, 1'b0, 1'b1));
    issue(other_event(OpKey, 8'h00));
    issue(other_event(OpKey, 8'hFF));
    issue(bus_event(16'h0080, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    issue(bus_event(16'h0081, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    issue(bus_event(16'h0081, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
    issue(bus_event(16'hFFBF, 8'hA5, 1'b1, 1'b0, 1'b0, 1'b1));
    issue(bus_event(16'h0081, 8'h5A, 1'b1, 1'b0, 1'b1, 1'b1));
    issue(bus_event(16'h0081, 8'hFF, 1'b1, 1'b1, 1'b0, 1'b1));
    issue(bus_event(16'h0081, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1));
    issue(bus_event(16'h00C1, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1));
    issue(bus_event(16'h0000, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1));
    issue(bus_event(16'hFFFF, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    issue(other_event(OpBusReset, 8'h00));
    issue(other_event(OpIgnored, 8'hFF));
    issue(bus_event(16'h0080, 8'h7F, 1'b1, 1'b0, 1'b0, 1'b1));
    issue(other_event(OpKey, 8'h3C));
    issue(bus_event(16'h0080, 8'h00, 1'b1, 1'b0, 1'b1, 1'b0));

    // Random traffic, then a full queue with dropped keys, then a drain
    random_events(200);
    idling = 1'b0;
    repeat (260) issue(other_event(OpKey, 8'($urandom_range(255))));
    idling = 1'b1;
    repeat (270) begin
      if ($urandom_range(99) < 85)
        issue(bus_event(chip_addr(1'b1), 8'($urandom_range(255)), 1'b1, 1'b0, 1'b1, 1'b0));
      else
        issue(random_event());
    end

    // Emulation off: accesses are ignored and keys pass through
    write_emulation(1'b0);
    random_events(200);

    // Emulation back on, first without gaps
    write_emulation(1'b1);
    idling = 1'b0;
    random_events(100);
    idling = 1'b1;
    random_events(150);

    drain();
    repeat (5) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/acia_pkg.sv
hdl/acia_rxq.sv
hdl/acia_uart_register_emulator.sv
dv/acia_uart_checker.sv
dv/tb_acia_uart_register_emulator.sv
